@@ rtl/core/line_closest_approach_macros.svh @@
// Assertion macros for the line closest approach block.
// Used by the top level only; needs nothing else.
`ifndef LINE_CLOSEST_APPROACH_MACROS_SVH
`define LINE_CLOSEST_APPROACH_MACROS_SVH

// Checks that prop holds at every clock edge outside reset.
`define LCA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("line_closest_approach: check failed");

// Checks that cons follows ante after the delay given by dly.
`define LCA_ASSERT_DELAY(lbl, clk, rst, ante, dly, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("line_closest_approach: timing check failed");

`endif

@@ rtl/core/lca_pkg.sv @@
// Shared types and constants for the line closest approach block.
// No dependencies; every module of the block imports it.
`default_nettype none
package lca_pkg;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] other_point_x;
      logic signed [31:0] other_point_y;
      logic signed [31:0] other_point_z;
      logic signed [31:0] other_dir_x;
      logic signed [31:0] other_dir_y;
      logic signed [31:0] other_dir_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] path_this;
      logic signed [31:0] path_other;
      logic               valid_res;
      logic               saturated;
   } rsp_type;

   // Dot products after rounding and clipping.
   typedef struct packed {
      logic signed [31:0] a;
      logic signed [33:0] b;
      logic signed [33:0] c;
   } dot_type;

   // Divider operands: magnitudes, signs and the shared denominator.
   typedef struct packed {
      logic [61:0] mag_this;
      logic [61:0] mag_other;
      logic        neg_this;
      logic        neg_other;
      logic [60:0] den;
      logic        den_zero;
   } frac_type;

   // Divider results before saturation.
   typedef struct packed {
      logic [32:0] q_this;
      logic [32:0] q_other;
      logic        ovf_this;
      logic        ovf_other;
      logic        neg_this;
      logic        neg_other;
      logic        den_zero;
   } quot_type;

   localparam int DIV_STEPS = 33;
   localparam int LATENCY   = 42;

endpackage
`default_nettype wire

@@ rtl/core/lca_front.sv @@
// Front pipeline: differences, direction clipping and the three dot products.
// Four register stages; depends on lca_pkg.
`default_nettype none
module lca_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  lca_pkg::req_type in_item,
   output logic             out_valid,
   output lca_pkg::dot_type out_dot
);
   import lca_pkg::*;

   localparam logic signed [31:0] UNIT_Q30 = 32'sh4000_0000;
   localparam logic signed [33:0] A_HI = 34'sh0_4000_0000;
   localparam logic signed [33:0] A_LO = -34'sh0_4000_0000;
   localparam logic signed [35:0] BC_HI = 36'sh1_FFFF_FFFF;
   localparam logic signed [35:0] BC_LO = -36'sh1_FFFF_FFFF;

   function automatic logic signed [31:0] clip_dir(input logic signed [31:0] x);
      if (x > UNIT_Q30) return UNIT_Q30;
      if (x < -UNIT_Q30) return -UNIT_Q30;
      return x;
   endfunction

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [32:0] w_ff [3];
   logic signed [32:0] w_in [3];
   logic signed [31:0] u_ff [3];
   logic signed [31:0] u_in [3];
   logic signed [31:0] v_ff [3];
   logic signed [31:0] v_in [3];
   logic signed [63:0] uv_ff [3];
   logic signed [63:0] uv_in [3];
   logic signed [61:0] wu_ff [3];
   logic signed [61:0] wu_in [3];
   logic signed [61:0] wv_ff [3];
   logic signed [61:0] wv_in [3];
   logic signed [63:0] wu_full [3];
   logic signed [63:0] wv_full [3];
   logic signed [63:0] a60_ff, a60_in, bs_ff, bs_in, cs_ff, cs_in;
   logic signed [63:0] a_rnd, b_rnd, c_rnd;
   logic signed [33:0] a_sh;
   logic signed [35:0] b_sh, c_sh;
   dot_type            dot_ff, dot_in;

   always_comb begin
      w_in[0] = 33'(in_item.point_x) - 33'(in_item.other_point_x);
      w_in[1] = 33'(in_item.point_y) - 33'(in_item.other_point_y);
      w_in[2] = 33'(in_item.point_z) - 33'(in_item.other_point_z);
      u_in[0] = clip_dir(in_item.dir_x);
      u_in[1] = clip_dir(in_item.dir_y);
      u_in[2] = clip_dir(in_item.dir_z);
      v_in[0] = clip_dir(in_item.other_dir_x);
      v_in[1] = clip_dir(in_item.other_dir_y);
      v_in[2] = clip_dir(in_item.other_dir_z);
   end

   // Products; the position products are floored by four right away.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         uv_in[i]   = u_ff[i] * v_ff[i];
         wu_full[i] = w_ff[i] * u_ff[i];
         wv_full[i] = w_ff[i] * v_ff[i];
         wu_in[i]   = wu_full[i][63:2];
         wv_in[i]   = wv_full[i][63:2];
      end
   end

   always_comb begin
      a60_in = uv_ff[0] + uv_ff[1] + uv_ff[2];
      bs_in  = 64'(wu_ff[0]) + 64'(wu_ff[1]) + 64'(wu_ff[2]);
      cs_in  = 64'(wv_ff[0]) + 64'(wv_ff[1]) + 64'(wv_ff[2]);
   end

   // Round half up, then clip.
   always_comb begin
      a_rnd = a60_ff + 64'sd536870912;
      b_rnd = bs_ff + 64'sd134217728;
      c_rnd = cs_ff + 64'sd134217728;
      a_sh  = a_rnd[63:30];
      b_sh  = b_rnd[63:28];
      c_sh  = c_rnd[63:28];
      if (a_sh > A_HI)      dot_in.a = UNIT_Q30;
      else if (a_sh < A_LO) dot_in.a = -UNIT_Q30;
      else                  dot_in.a = a_sh[31:0];
      if (b_sh > BC_HI)      dot_in.b = BC_HI[33:0];
      else if (b_sh < BC_LO) dot_in.b = BC_LO[33:0];
      else                   dot_in.b = b_sh[33:0];
      if (c_sh > BC_HI)      dot_in.c = BC_HI[33:0];
      else if (c_sh < BC_LO) dot_in.c = BC_LO[33:0];
      else                   dot_in.c = c_sh[33:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      uv_ff  <= uv_in;
      wu_ff  <= wu_in;
      wv_ff  <= wv_in;
      a60_ff <= a60_in;
      bs_ff  <= bs_in;
      cs_ff  <= cs_in;
      dot_ff <= dot_in;
   end

   assign out_valid = v4_ff;
   assign out_dot   = dot_ff;
endmodule
`default_nettype wire

@@ rtl/core/lca_numer.sv @@
// Numerator and denominator pipeline: products of a, then sign and magnitude.
// Three register stages; depends on lca_pkg.
`default_nettype none
module lca_numer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lca_pkg::dot_type  in_dot,
   output logic              out_valid,
   output lca_pkg::frac_type out_frac
);
   import lca_pkg::*;

   localparam logic signed [63:0] UNIT_Q60 = 64'sh1000_0000_0000_0000;

   logic               v5_ff, v6_ff, v7_ff;
   logic signed [63:0] aa_ff, aa_in, ac_ff, ac_in, ab_ff, ab_in;
   logic signed [33:0] b_ff, c_ff;
   logic signed [63:0] den_full;
   logic signed [63:0] nt_ff, nt_in, no_ff, no_in;
   logic        [60:0] den_ff, den_in;
   logic signed [63:0] nt_abs, no_abs;
   frac_type           frac_ff, frac_in;

   always_comb begin
      aa_in = in_dot.a * in_dot.a;
      ac_in = in_dot.a * in_dot.c;
      ab_in = in_dot.a * in_dot.b;
   end

   always_comb begin
      den_full = UNIT_Q60 - aa_ff;
      den_in   = den_full[60:0];
      nt_in    = (ac_ff >>> 2) - (64'(b_ff) <<< 28);
      no_in    = (64'(c_ff) <<< 28) - (ab_ff >>> 2);
   end

   always_comb begin
      nt_abs             = nt_ff[63] ? -nt_ff : nt_ff;
      no_abs             = no_ff[63] ? -no_ff : no_ff;
      frac_in.mag_this   = nt_abs[61:0];
      frac_in.mag_other  = no_abs[61:0];
      frac_in.neg_this   = nt_ff[63];
      frac_in.neg_other  = no_ff[63];
      frac_in.den        = den_ff;
      frac_in.den_zero   = (den_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v5_ff <= in_valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      aa_ff   <= aa_in;
      ac_ff   <= ac_in;
      ab_ff   <= ab_in;
      b_ff    <= in_dot.b;
      c_ff    <= in_dot.c;
      den_ff  <= den_in;
      nt_ff   <= nt_in;
      no_ff   <= no_in;
      frac_ff <= frac_in;
   end

   assign out_valid = v7_ff;
   assign out_frac  = frac_ff;
endmodule
`default_nettype wire

@@ rtl/core/lca_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Gives floor(mag * 2^32 / den) for quotients below 2^33; depends on lca_pkg.
`default_nettype none
module lca_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lca_pkg::frac_type in_frac,
   output logic              out_valid,
   output lca_pkg::quot_type out_quot
);
   import lca_pkg::*;

   logic        val_ff  [DIV_STEPS+1];
   logic [61:0] rt_ff   [DIV_STEPS+1];
   logic [61:0] ro_ff   [DIV_STEPS+1];
   logic [32:0] qt_ff   [DIV_STEPS+1];
   logic [32:0] qo_ff   [DIV_STEPS+1];
   logic [60:0] den_ff  [DIV_STEPS+1];
   logic        ovt_ff  [DIV_STEPS+1];
   logic        ovo_ff  [DIV_STEPS+1];
   logic        negt_ff [DIV_STEPS+1];
   logic        nego_ff [DIV_STEPS+1];
   logic        dz_ff   [DIV_STEPS+1];

   // Entry stage: a magnitude of at least twice the denominator overflows.
   always_ff @(posedge clock) begin
      if (reset) val_ff[0] <= 1'b0;
      else       val_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      rt_ff[0]   <= in_frac.mag_this;
      ro_ff[0]   <= in_frac.mag_other;
      qt_ff[0]   <= '0;
      qo_ff[0]   <= '0;
      den_ff[0]  <= in_frac.den;
      ovt_ff[0]  <= {1'b0, in_frac.mag_this} >= {1'b0, in_frac.den, 1'b0};
      ovo_ff[0]  <= {1'b0, in_frac.mag_other} >= {1'b0, in_frac.den, 1'b0};
      negt_ff[0] <= in_frac.neg_this;
      nego_ff[0] <= in_frac.neg_other;
      dz_ff[0]   <= in_frac.den_zero;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic        ge_t, ge_o;
      logic [61:0] rt_sub, ro_sub;

      always_comb begin
         ge_t   = rt_ff[k] >= {1'b0, den_ff[k]};
         ge_o   = ro_ff[k] >= {1'b0, den_ff[k]};
         rt_sub = ge_t ? rt_ff[k] - {1'b0, den_ff[k]} : rt_ff[k];
         ro_sub = ge_o ? ro_ff[k] - {1'b0, den_ff[k]} : ro_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) val_ff[k+1] <= 1'b0;
         else       val_ff[k+1] <= val_ff[k];
      end

      always_ff @(posedge clock) begin
         rt_ff[k+1]   <= {rt_sub[60:0], 1'b0};
         ro_ff[k+1]   <= {ro_sub[60:0], 1'b0};
         qt_ff[k+1]   <= {qt_ff[k][31:0], ge_t};
         qo_ff[k+1]   <= {qo_ff[k][31:0], ge_o};
         den_ff[k+1]  <= den_ff[k];
         ovt_ff[k+1]  <= ovt_ff[k];
         ovo_ff[k+1]  <= ovo_ff[k];
         negt_ff[k+1] <= negt_ff[k];
         nego_ff[k+1] <= nego_ff[k];
         dz_ff[k+1]   <= dz_ff[k];
      end
   end

   always_comb begin
      out_valid          = val_ff[DIV_STEPS];
      out_quot.q_this    = qt_ff[DIV_STEPS];
      out_quot.q_other   = qo_ff[DIV_STEPS];
      out_quot.ovf_this  = ovt_ff[DIV_STEPS];
      out_quot.ovf_other = ovo_ff[DIV_STEPS];
      out_quot.neg_this  = negt_ff[DIV_STEPS];
      out_quot.neg_other = nego_ff[DIV_STEPS];
      out_quot.den_zero  = dz_ff[DIV_STEPS];
   end
endmodule
`default_nettype wire

@@ rtl/core/line_closest_approach.sv @@
// Top level of the line closest approach block: front, numerator, divider.
// Depends on lca_pkg, lca_front, lca_numer, lca_div and the macros header.
// A new item is taken in every cycle (busy stays low) and its result shows on
// the rsp_ ports, with rsp_strobe high for one cycle, after passing through
// nine arithmetic stages and the 33 one-bit steps of the quotient pipeline.
// Results come out in input order and cannot be held off, so the receiver
// must take one in every cycle.
`default_nettype none
module line_closest_approach (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lca_pkg::req_type req_item,
   output logic             rsp_strobe,
   output lca_pkg::rsp_type rsp_item
);
   import lca_pkg::*;

   logic     front_valid, numer_valid, div_valid;
   dot_type  dot;
   frac_type frac;
   quot_type quot;
   logic     strobe_ff;
   rsp_type  rsp_ff, rsp_in;
   logic     accept;

   logic [32:0] lim_t, lim_o, mag_t, mag_o;
   logic        sat_t, sat_o;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   lca_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_dot   (dot)
   );

   lca_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_dot    (dot),
      .out_valid (numer_valid),
      .out_frac  (frac)
   );

   lca_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (numer_valid),
      .in_frac   (frac),
      .out_valid (div_valid),
      .out_quot  (quot)
   );

   // Negative quotients may reach 2^31, positive ones only 2^31-1.
   always_comb begin
      lim_t = quot.neg_this  ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      lim_o = quot.neg_other ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      sat_t = quot.ovf_this  || (quot.q_this > lim_t);
      sat_o = quot.ovf_other || (quot.q_other > lim_o);
      mag_t = sat_t ? lim_t : quot.q_this;
      mag_o = sat_o ? lim_o : quot.q_other;
      if (quot.den_zero) begin
         rsp_in.path_this  = '0;
         rsp_in.path_other = '0;
         rsp_in.valid_res  = 1'b0;
         rsp_in.saturated  = 1'b0;
      end else begin
         rsp_in.path_this  = quot.neg_this  ? -mag_t[31:0] : mag_t[31:0];
         rsp_in.path_other = quot.neg_other ? -mag_o[31:0] : mag_o[31:0];
         rsp_in.valid_res  = 1'b1;
         rsp_in.saturated  = sat_t || sat_o;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= div_valid;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

`include "line_closest_approach_macros.svh"

   `LCA_ASSERT_DELAY(a_latency, clock, reset, accept, LATENCY, rsp_strobe)
   `LCA_ASSERT(a_parallel_zero, clock, reset,
      !(rsp_strobe && !rsp_item.valid_res) || (!rsp_item.saturated &&
      rsp_item.path_this == '0 && rsp_item.path_other == '0))
   `LCA_ASSERT(a_sat_clip, clock, reset,
      !(rsp_strobe && rsp_item.saturated && !quot.den_zero) || rsp_item.valid_res)

endmodule
`default_nettype wire
